>>> rtl/core/aksd_pkg.sv
// Package: shared types, character constants and key lookup functions of the key decoder.
package aksd_pkg;

	typedef enum logic [1:0] {
		PH_IDLE  = 2'd0,
		PH_ESC   = 2'd1,
		PH_CSI   = 2'd2,
		PH_DIGIT = 2'd3
	} phase_t;

	typedef enum logic [1:0] {
		KIND_RAW  = 2'd0,
		KIND_KEY  = 2'd1,
		KIND_NONE = 2'd2
	} kind_t;

	localparam logic [7:0] CH_ESC      = 8'h1B;
	localparam logic [7:0] CH_LBRACKET = 8'h5B;
	localparam logic [7:0] CH_TILDE    = 8'h7E;
	localparam logic [7:0] CH_UP       = 8'h41;
	localparam logic [7:0] CH_DOWN     = 8'h42;
	localparam logic [7:0] CH_RIGHT    = 8'h43;
	localparam logic [7:0] CH_LEFT     = 8'h44;
	localparam logic [7:0] CH_HOME     = 8'h48;
	localparam logic [7:0] CH_END      = 8'h46;
	localparam logic [7:0] CH_ZERO     = 8'h30;
	localparam logic [7:0] CH_NINE     = 8'h39;
	localparam logic [7:0] CH_ONE      = 8'h31;
	localparam logic [7:0] CH_THREE    = 8'h33;
	localparam logic [7:0] CH_FOUR     = 8'h34;
	localparam logic [7:0] CH_FIVE     = 8'h35;
	localparam logic [7:0] CH_SIX      = 8'h36;

	localparam logic [7:0] KEY_UP         = 8'd0;
	localparam logic [7:0] KEY_ARROW_DN   = 8'd1;
	localparam logic [7:0] KEY_ARROW_RT   = 8'd2;
	localparam logic [7:0] KEY_ARROW_LT   = 8'd3;
	localparam logic [7:0] KEY_LINE_START = 8'd4;
	localparam logic [7:0] KEY_END        = 8'd5;
	localparam logic [7:0] KEY_DELETE     = 8'd6;
	localparam logic [7:0] KEY_PGUP       = 8'd7;
	localparam logic [7:0] KEY_PGDN       = 8'd8;

	// Lookup result: hit flag and key code.
	typedef struct packed {
		logic       hit;
		logic [7:0] code;
	} key_lut_t;

	// Parser state carried between requests.
	typedef struct packed {
		phase_t     phase;
		logic [7:0] held_digit;
	} parse_state_t;

	// Outcome of decoding one request.
	typedef struct packed {
		logic       emit;
		kind_t      kind;
		logic [7:0] code;
	} decode_res_t;

	// Final byte of ESC [ x.
	function automatic key_lut_t letter_key(input logic [7:0] b);
		key_lut_t r;
		r.hit = 1'b1;
		unique case (b)
			CH_UP:    r.code = KEY_UP;
			CH_DOWN:  r.code = KEY_ARROW_DN;
			CH_RIGHT: r.code = KEY_ARROW_RT;
			CH_LEFT:  r.code = KEY_ARROW_LT;
			CH_HOME:  r.code = KEY_LINE_START;
			CH_END:   r.code = KEY_END;
			default: begin
				r.hit  = 1'b0;
				r.code = KEY_UP;
			end
		endcase
		return r;
	endfunction

	// Digit of ESC [ d ~.
	function automatic key_lut_t digit_key(input logic [7:0] d);
		key_lut_t r;
		r.hit = 1'b1;
		unique case (d)
			CH_ONE:   r.code = KEY_LINE_START;
			CH_THREE: r.code = KEY_DELETE;
			CH_FOUR:  r.code = KEY_END;
			CH_FIVE:  r.code = KEY_PGUP;
			CH_SIX:   r.code = KEY_PGDN;
			default: begin
				r.hit  = 1'b0;
				r.code = KEY_UP;
			end
		endcase
		return r;
	endfunction

endpackage

>>> rtl/core/aksd_if.sv
// Interfaces: byte request channel and key result channel.
interface aksd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       no_data;

	modport source (output valid, output in_byte, output no_data, input ready);
	modport sink (input valid, input in_byte, input no_data, output ready);
endinterface

interface aksd_out_if;
	logic       valid;
	logic       ready;
	logic [1:0] result_kind;
	logic [7:0] result_code;

	modport source (output valid, output result_kind, output result_code, input ready);
	modport sink (input valid, input result_kind, input result_code, output ready);
endinterface

>>> rtl/core/aksd_decode.sv
// Decode step: next parser state and optional result for one request.
module aksd_decode (
	input  aksd_pkg::parse_state_t cur,
	input  logic                   keypad_enable,
	input  logic [7:0]             in_byte,
	input  logic                   no_data,
	output aksd_pkg::parse_state_t nxt,
	output aksd_pkg::decode_res_t  res
);

	aksd_pkg::key_lut_t letter;
	aksd_pkg::key_lut_t digit;
	logic               is_digit;

	assign letter   = aksd_pkg::letter_key(in_byte);
	assign digit    = aksd_pkg::digit_key(cur.held_digit);
	assign is_digit = (in_byte >= aksd_pkg::CH_ZERO) && (in_byte <= aksd_pkg::CH_NINE);

	always_comb begin
		nxt      = cur;
		res.emit = 1'b1;
		res.kind = aksd_pkg::KIND_RAW;
		res.code = aksd_pkg::CH_ESC;
		unique case (cur.phase)
			aksd_pkg::PH_IDLE: begin
				if (no_data) begin
					res.kind = aksd_pkg::KIND_NONE;
					res.code = 8'd0;
				end else if (in_byte != aksd_pkg::CH_ESC || !keypad_enable) begin
					res.code = in_byte;
				end else begin
					res.emit  = 1'b0;
					nxt.phase = aksd_pkg::PH_ESC;
				end
			end
			aksd_pkg::PH_ESC: begin
				nxt.phase = aksd_pkg::PH_IDLE;
				if (!no_data && in_byte == aksd_pkg::CH_LBRACKET) begin
					res.emit  = 1'b0;
					nxt.phase = aksd_pkg::PH_CSI;
				end
			end
			aksd_pkg::PH_CSI: begin
				nxt.phase = aksd_pkg::PH_IDLE;
				if (!no_data) begin
					if (letter.hit) begin
						res.kind = aksd_pkg::KIND_KEY;
						res.code = letter.code;
					end else if (is_digit) begin
						res.emit       = 1'b0;
						nxt.phase      = aksd_pkg::PH_DIGIT;
						nxt.held_digit = in_byte;
					end
				end
			end
			aksd_pkg::PH_DIGIT: begin
				nxt.phase = aksd_pkg::PH_IDLE;
				if (!no_data && in_byte == aksd_pkg::CH_TILDE && digit.hit) begin
					res.kind = aksd_pkg::KIND_KEY;
					res.code = digit.code;
				end
			end
			default: begin
				nxt.phase = aksd_pkg::PH_IDLE;
			end
		endcase
	end

endmodule

>>> rtl/core/ansi_key_sequence_decoder.sv
// Top level: ANSI keypad sequence decoder with input and result registers.
//
// Takes terminal bytes (or no-data events) on byte_chan and returns keys on key_chan.
// With keypad_enable set, ESC [ A/B/C/D/H/F and ESC [ 1/3/4/5/6 ~ become special
// keys (kind 1); other bytes pass as raw (kind 0); a broken or unknown sequence
// yields a raw ESC and the breaking byte is lost; no data while idle gives kind 2.
// One request is taken every cycle while the result slot is free or being read out.
// The request lands in the input register at acceptance, and the single decode
// pass writes the result register when the request moves on, where it shows
// on key_chan. The input is held off only while a result waits with key_chan.ready
// low. A request that opens or continues a sequence yields no result. keypad_enable
// is written through cfg_we/cfg_wdata, by the user only while the block is idle;
// the block does not enforce this. It is only looked at when no sequence is in progress.
module ansi_key_sequence_decoder (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic              cfg_wdata,
	aksd_in_if.sink           byte_chan,
	aksd_out_if.source        key_chan
);

	// keypad enable register
	logic                   keypad_enable_q;

	// input register
	logic                   valid_s1;
	logic [7:0]             byte_s1;
	logic                   no_data_s1;

	// parser state and result register
	aksd_pkg::parse_state_t state_q;
	aksd_pkg::parse_state_t state_nxt;
	aksd_pkg::decode_res_t  dec;
	logic                   out_valid_q;
	aksd_pkg::kind_t        out_kind_q;
	logic [7:0]             out_code_q;

	logic                   advance;

	// s1 moves on when the result slot is free or being emptied this cycle
	assign advance         = valid_s1 && (!out_valid_q || key_chan.ready);
	assign byte_chan.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			keypad_enable_q <= 1'b0;
		end else if (cfg_we) begin
			keypad_enable_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_chan.ready) begin
			valid_s1 <= byte_chan.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_chan.ready && byte_chan.valid) begin
			byte_s1    <= byte_chan.in_byte;
			no_data_s1 <= byte_chan.no_data;
		end
	end

	aksd_decode u_decode (
		.cur           (state_q),
		.keypad_enable (keypad_enable_q),
		.in_byte       (byte_s1),
		.no_data       (no_data_s1),
		.nxt           (state_nxt),
		.res           (dec)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.phase      <= aksd_pkg::PH_IDLE;
			state_q.held_digit <= 8'd0;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= dec.emit;
		end else if (key_chan.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && dec.emit) begin
			out_kind_q <= dec.kind;
			out_code_q <= dec.code;
		end
	end

	assign key_chan.valid       = out_valid_q;
	assign key_chan.result_kind = out_kind_q;
	assign key_chan.result_code = out_code_q;

`ifndef SYNTHESIS
	// no data inside a sequence aborts it with a raw ESC
	a_abort_esc: assert property (@(posedge clk) disable iff (!arst_n)
		advance && no_data_s1 && state_q.phase != aksd_pkg::PH_IDLE
		|=> out_valid_q && out_kind_q == aksd_pkg::KIND_RAW
			&& out_code_q == aksd_pkg::CH_ESC && state_q.phase == aksd_pkg::PH_IDLE)
		else $error("sequence not aborted on no-data request");

	// a held digit is always an ASCII digit
	a_digit_held: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.phase == aksd_pkg::PH_DIGIT
		|-> state_q.held_digit >= aksd_pkg::CH_ZERO
			&& state_q.held_digit <= aksd_pkg::CH_NINE)
		else $error("digit phase without a digit held");

	// input is only back-pressured by a stalled full result slot
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!byte_chan.ready |-> valid_s1 && out_valid_q && !key_chan.ready)
		else $error("input stalled without cause");

	// a no-input result carries code zero
	a_none_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_kind_q == aksd_pkg::KIND_NONE |-> out_code_q == 8'd0)
		else $error("no-input result with non-zero code");
`endif

endmodule

>>> sim/ansi_key_sequence_decoder_test.sv
// Testbench for the ANSI key sequence decoder: directed table, random sequences, self-checking.
`timescale 1ns / 1ps

module ansi_key_sequence_decoder_test;

	// Cycles with no request moving on either channel before the run is called hung.
	// The slowest correct run idles only during sender gaps, receiver holds and register
	// writes, each far shorter than this, so this is many times over.
	localparam int STALL_LIMIT = 1000;
	// Cycles to let the pipeline drain once nothing is owed (two stages, plus margin).
	localparam int DRAIN_CYCLES = 4;
	localparam int RANDOM_PHASES = 6;
	localparam int PHASE_REQUESTS = 190;

	// One decoded key as the channel returns it; emit is low for a request that only
	// moves the parser along.
	typedef struct packed {
		logic            emit;
		aksd_pkg::kind_t kind;
		logic [7:0]      code;
	} key_result_t;

	typedef enum bit {ROW_REQ, ROW_CFG} row_op_t;

	// Directed row: a request (or a keypad write, value in data[0]). Where fixed is set
	// the expected key is typed in; otherwise the predictor supplies it.
	typedef struct {
		row_op_t     op;
		logic [7:0]  data;
		logic        nd;
		bit          fixed;
		key_result_t res;
	} stim_row_t;

	typedef enum {SINK_OPEN, SINK_RANDOM, SINK_EVERY_4TH, SINK_LONG_HOLD} sink_mode_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic cfg_wdata;

	aksd_in_if  byte_chan ();
	aksd_out_if key_chan ();

	ansi_key_sequence_decoder i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.byte_chan (byte_chan),
		.key_chan  (key_chan)
	);

	// Predictor copy of the parser and the keypad register.
	aksd_pkg::phase_t parse_ph;
	logic [7:0]       digit_held;
	logic             decode_on;

	key_result_t keys_due[$];
	int          mismatches;
	int          requests_sent;
	int          burst_left;
	int          idle_cycles;

	logic [7:0] final_letters [6] = '{aksd_pkg::CH_UP, aksd_pkg::CH_DOWN, aksd_pkg::CH_RIGHT,
		aksd_pkg::CH_LEFT, aksd_pkg::CH_HOME, aksd_pkg::CH_END};
	logic [7:0] key_digits [5]    = '{aksd_pkg::CH_ONE, aksd_pkg::CH_THREE, aksd_pkg::CH_FOUR,
		aksd_pkg::CH_FIVE, aksd_pkg::CH_SIX};
	bit         phase_keypad [RANDOM_PHASES] = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1};

	// Directed part. Keypad is off out of reset, so the first rows are plain pass-through.
	stim_row_t directed_rows [28] = '{
		// decoding off: byte extremes, ESC passes raw, no data gives no-input
		'{ROW_REQ, 8'h00,                 1'b0, 1'b1, '{1'b1, aksd_pkg::KIND_RAW, 8'h00}},
		'{ROW_REQ, 8'hFF,                 1'b0, 1'b1, '{1'b1, aksd_pkg::KIND_RAW, 8'hFF}},
		'{ROW_REQ, aksd_pkg::CH_ESC,      1'b0, 1'b1,
			'{1'b1, aksd_pkg::KIND_RAW, aksd_pkg::CH_ESC}},
		'{ROW_REQ, aksd_pkg::CH_ESC,      1'b1, 1'b1, '{1'b1, aksd_pkg::KIND_NONE, 8'h00}},
		'{ROW_CFG, 8'h01,                 1'b0, 1'b0, '0},
		// ESC [ 6 ~ : page down
		'{ROW_REQ, aksd_pkg::CH_ESC,      1'b0, 1'b0, '0},
		'{ROW_REQ, aksd_pkg::CH_LBRACKET, 1'b0, 1'b0, '0},
		'{ROW_REQ, aksd_pkg::CH_SIX,      1'b0, 1'b0, '0},
		'{ROW_REQ, aksd_pkg::CH_TILDE,    1'b0, 1'b0, '0},
		// tilde after a digit that is no key
		'{ROW_REQ, aksd_pkg::CH_ESC,      1'b0, 1'b0, '0},
		'{ROW_REQ, aksd_pkg::CH_LBRACKET, 1'b0, 1'b0, '0},
		'{ROW_REQ, 8'h32,                 1'b0, 1'b0, '0},
		'{ROW_REQ, aksd_pkg::CH_TILDE,    1'b0, 1'b1,
			'{1'b1, aksd_pkg::KIND_RAW, aksd_pkg::CH_ESC}},
		// wrong byte straight after ESC
		'{ROW_REQ, aksd_pkg::CH_ESC,      1'b0, 1'b0, '0},
		'{ROW_REQ, 8'h58,                 1'b0, 1'b1,
			'{1'b1, aksd_pkg::KIND_RAW, aksd_pkg::CH_ESC}},
		// unknown final byte after ESC [
		'{ROW_REQ, aksd_pkg::CH_ESC,      1'b0, 1'b0, '0},
		'{ROW_REQ, aksd_pkg::CH_LBRACKET, 1'b0, 1'b0, '0},
		'{ROW_REQ, 8'h5A,                 1'b0, 1'b1,
			'{1'b1, aksd_pkg::KIND_RAW, aksd_pkg::CH_ESC}},
		// digit with no tilde after it
		'{ROW_REQ, aksd_pkg::CH_ESC,      1'b0, 1'b0, '0},
		'{ROW_REQ, aksd_pkg::CH_LBRACKET, 1'b0, 1'b0, '0},
		'{ROW_REQ, aksd_pkg::CH_FIVE,     1'b0, 1'b0, '0},
		'{ROW_REQ, 8'h58,                 1'b0, 1'b1,
			'{1'b1, aksd_pkg::KIND_RAW, aksd_pkg::CH_ESC}},
		// no data in the middle of a sequence
		'{ROW_REQ, aksd_pkg::CH_ESC,      1'b0, 1'b0, '0},
		'{ROW_REQ, aksd_pkg::CH_LBRACKET, 1'b1, 1'b1,
			'{1'b1, aksd_pkg::KIND_RAW, aksd_pkg::CH_ESC}},
		// decoding switched off with ESC [ pending: the sequence still completes
		'{ROW_REQ, aksd_pkg::CH_ESC,      1'b0, 1'b0, '0},
		'{ROW_REQ, aksd_pkg::CH_LBRACKET, 1'b0, 1'b0, '0},
		'{ROW_CFG, 8'h00,                 1'b0, 1'b0, '0},
		'{ROW_REQ, aksd_pkg::CH_HOME,     1'b0, 1'b0, '0}
	};

	// Steps the predictor by one accepted request and returns the key it owes.
	function automatic key_result_t next_key(input logic [7:0] b, input logic nd);
		key_result_t r;
		logic [7:0]  k;
		bit          hit;
		r   = '{1'b1, aksd_pkg::KIND_RAW, aksd_pkg::CH_ESC};
		k   = aksd_pkg::KEY_UP;
		hit = 1'b0;
		// decode_on only matters here; a started sequence runs to its end regardless
		if (parse_ph == aksd_pkg::PH_IDLE) begin
			if (nd)
				r = '{1'b1, aksd_pkg::KIND_NONE, 8'h00};
			else if (b != aksd_pkg::CH_ESC || !decode_on)
				r.code = b;
			else begin
				parse_ph = aksd_pkg::PH_ESC;
				r.emit = 1'b0;
			end
			return r;
		end
		// no data inside a sequence aborts it with a raw ESC
		if (nd) begin
			parse_ph = aksd_pkg::PH_IDLE;
			return r;
		end
		case (parse_ph)
			aksd_pkg::PH_ESC: begin
				if (b == aksd_pkg::CH_LBRACKET) begin
					parse_ph = aksd_pkg::PH_CSI;
					r.emit = 1'b0;
				end else
					parse_ph = aksd_pkg::PH_IDLE;
			end
			aksd_pkg::PH_CSI: begin
				parse_ph = aksd_pkg::PH_IDLE;
				hit = 1'b1;
				case (b)
					aksd_pkg::CH_UP:    k = aksd_pkg::KEY_UP;
					aksd_pkg::CH_DOWN:  k = aksd_pkg::KEY_ARROW_DN;
					aksd_pkg::CH_RIGHT: k = aksd_pkg::KEY_ARROW_RT;
					aksd_pkg::CH_LEFT:  k = aksd_pkg::KEY_ARROW_LT;
					aksd_pkg::CH_HOME:  k = aksd_pkg::KEY_LINE_START;
					aksd_pkg::CH_END:   k = aksd_pkg::KEY_END;
					default: begin
						hit = 1'b0;
						if (b >= aksd_pkg::CH_ZERO && b <= aksd_pkg::CH_NINE) begin
							digit_held = b;
							parse_ph = aksd_pkg::PH_DIGIT;
							r.emit = 1'b0;
						end
					end
				endcase
			end
			default: begin
				// digit held: only a tilde after a key digit gives a key
				parse_ph = aksd_pkg::PH_IDLE;
				hit = (b == aksd_pkg::CH_TILDE);
				case (digit_held)
					aksd_pkg::CH_ONE:   k = aksd_pkg::KEY_LINE_START;
					aksd_pkg::CH_THREE: k = aksd_pkg::KEY_DELETE;
					aksd_pkg::CH_FOUR:  k = aksd_pkg::KEY_END;
					aksd_pkg::CH_FIVE:  k = aksd_pkg::KEY_PGUP;
					aksd_pkg::CH_SIX:   k = aksd_pkg::KEY_PGDN;
					default:            hit = 1'b0;
				endcase
			end
		endcase
		if (hit) begin
			r.kind = aksd_pkg::KIND_KEY;
			r.code = k;
		end
		return r;
	endfunction

	task automatic report_mismatch(input string what);
		$display("%0t ns: mismatch: %s", $time, what);
		mismatches++;
	endtask

	// Sends one request in the sender's burst pattern and logs the key it owes.
	task automatic send_request(input logic [7:0] b, input logic nd,
			input bit fixed = 1'b0, input key_result_t fixed_res = '0);
		int          gap;
		key_result_t r;
		if (burst_left == 0) begin
			// a quarter of the bursts follow on with no gap at all
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap != 0) begin
				byte_chan.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 32);
		end
		burst_left--;
		byte_chan.valid   <= 1'b1;
		byte_chan.in_byte <= b;
		byte_chan.no_data <= nd;
		// values read just after the edge are the ones the edge sampled
		do
			@(posedge clk);
		while (!byte_chan.ready);
		r = next_key(b, nd);
		if (fixed)
			r = fixed_res;
		if (r.emit)
			keys_due.push_back(r);
		requests_sent++;
	endtask

	// Keypad write: only once every owed key is back and the pipeline has drained,
	// since a request mid-sequence owes nothing and may still be in flight.
	task automatic write_keypad(input logic v);
		byte_chan.valid <= 1'b0;
		while (keys_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		decode_on = v;
		cfg_we <= 1'b0;
		burst_left = 0;
	endtask

	// One random sequence, mostly well formed so the deeper phases get exercised.
	task automatic play_random_sequence();
		int         pick;
		logic [7:0] dig;
		pick = $urandom_range(0, 99);
		dig  = ($urandom_range(0, 9) < 7) ? key_digits[$urandom_range(0, 4)]
			: 8'($urandom_range(aksd_pkg::CH_ZERO, aksd_pkg::CH_NINE));
		if (pick < 30) begin
			send_request(aksd_pkg::CH_ESC, 1'b0);
			send_request(aksd_pkg::CH_LBRACKET, 1'b0);
			send_request(final_letters[$urandom_range(0, 5)], 1'b0);
		end else if (pick < 55) begin
			send_request(aksd_pkg::CH_ESC, 1'b0);
			send_request(aksd_pkg::CH_LBRACKET, 1'b0);
			send_request(dig, 1'b0);
			send_request(aksd_pkg::CH_TILDE, 1'b0);
		end else if (pick < 72)
			send_request(8'($urandom), 1'b0);
		else if (pick < 80)
			send_request(8'($urandom), 1'b1);
		else begin
			// broken sequence: a prefix, then noise or no data
			send_request(aksd_pkg::CH_ESC, 1'b0);
			if (pick >= 87)
				send_request(aksd_pkg::CH_LBRACKET, 1'b0);
			if (pick >= 94)
				send_request(dig, 1'b0);
			send_request(8'($urandom), $urandom_range(0, 3) == 0);
		end
	endtask

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Receiver: switches between randomly chosen stall patterns.
	initial begin : key_sink
		sink_mode_t mode;
		int         left;
		int         hold;
		key_chan.ready <= 1'b0;
		mode = SINK_OPEN;
		left = 0;
		hold = 0;
		forever begin
			@(posedge clk);
			if (left == 0) begin
				mode = sink_mode_t'($urandom_range(0, 3));
				left = $urandom_range(20, 80);
			end
			left--;
			case (mode)
				SINK_OPEN:      key_chan.ready <= 1'b1;
				SINK_RANDOM:    key_chan.ready <= 1'($urandom_range(0, 1));
				SINK_EVERY_4TH: key_chan.ready <= (left % 4 == 0);
				default: begin
					if (hold == 0)
						hold = $urandom_range(1, 12);
					hold--;
					key_chan.ready <= (hold == 0);
				end
			endcase
		end
	end

	// Result check: each accepted key against the oldest one owed.
	always @(posedge clk) begin : key_check
		key_result_t want;
		if (arst_n && key_chan.valid && key_chan.ready) begin
			if (keys_due.size() == 0)
				report_mismatch($sformatf("key with none owed: kind %0d code %02h",
					key_chan.result_kind, key_chan.result_code));
			else begin
				want = keys_due.pop_front();
				if (key_chan.result_kind != want.kind)
					report_mismatch($sformatf("kind %0d, want %0d",
						key_chan.result_kind, want.kind));
				if (key_chan.result_code != want.code)
					report_mismatch($sformatf("code %02h, want %02h",
						key_chan.result_code, want.code));
			end
		end
	end

	// Watchdog: counts cycles with no request moving on either side.
	always @(posedge clk) begin
		if ((byte_chan.valid && byte_chan.ready) || (key_chan.valid && key_chan.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles == STALL_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin
		int p;
		int target;
		arst_n            <= 1'b0;
		cfg_we            <= 1'b0;
		cfg_wdata         <= 1'b0;
		byte_chan.valid   <= 1'b0;
		byte_chan.in_byte <= 8'h00;
		byte_chan.no_data <= 1'b0;
		idle_cycles       = 0;
		mismatches        = 0;
		requests_sent     = 0;
		burst_left        = 0;
		parse_ph          = aksd_pkg::PH_IDLE;
		digit_held        = 8'h00;
		decode_on         = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			if (directed_rows[i].op == ROW_CFG)
				write_keypad(directed_rows[i].data[0]);
			else
				send_request(directed_rows[i].data, directed_rows[i].nd,
					directed_rows[i].fixed, directed_rows[i].res);
		end

		// random phases, keypad toggled between them (parser may be mid-sequence)
		for (p = 0; p < RANDOM_PHASES; p++) begin
			write_keypad(phase_keypad[p]);
			target = requests_sent + PHASE_REQUESTS;
			while (requests_sent < target)
				play_random_sequence();
		end

		byte_chan.valid <= 1'b0;
		while (keys_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

>>> sim.f
rtl/core/aksd_pkg.sv
rtl/core/aksd_if.sv
rtl/core/aksd_decode.sv
rtl/core/ansi_key_sequence_decoder.sv
sim/ansi_key_sequence_decoder_test.sv
